[sv/slt_pkg.sv]
// Package for the source line tokenizer: scan modes, event codes, the result
// record and the byte classification helpers. No dependencies.
package slt_pkg;

    localparam int VALUE_WIDTH = 32;

    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h27;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CTRL_LIMIT    = 8'h20;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_LIT    = 3'd3,
        MODE_CLOSE  = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        EV_ID_START = 3'd0,
        EV_ID_CONT  = 3'd1,
        EV_ID_END   = 3'd2,
        EV_NUMBER   = 3'd3,
        EV_CHAR     = 3'd4,
        EV_SYMBOL   = 3'd5,
        EV_LINE_END = 3'd6
    } event_t;

    typedef struct packed {
        event_t      event_res;
        logic [7:0]  char_out;
        logic [31:0] token_value;
        logic        last;
    } result_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

[sv/slt_byte_if.sv]
// Byte channel into the tokenizer: valid/ready handshake with one source byte.
// Depends on nothing.
interface slt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

[sv/slt_token_if.sv]
// Token event channel out of the tokenizer: valid/ready handshake with one
// result record. Depends on nothing.
interface slt_token_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [7:0]  char_out;
    logic [31:0] token_value;
    logic        last;

    modport source (output valid, output event_res, output char_out,
                    output token_value, output last, input ready);
    modport sink   (input valid, input event_res, input char_out,
                    input token_value, input last, output ready);
endinterface

[sv/source_line_tokenizer_core.sv]
// Top level of the source line tokenizer: input register, scan logic and a
// two-entry result buffer. Depends on slt_pkg, slt_byte_if and slt_token_if.
//
//   channel   direction   beat
//   in_ch     sink        one source byte (in_byte)
//   out_ch    source      one token event (event_res, char_out, token_value, last)
//
// An accepted byte is scanned from the input register and yields zero, one or two
// events; a new byte can be accepted every cycle while the result buffer has room.
// Sustained rate is one byte per cycle while out_ch is ready, limited by the single
// output port when a byte yields two events (one event per cycle).
// The two-entry result buffer lets the scan continue while an event waits.
// Reset returns to the idle mode with a cleared number accumulator.
module source_line_tokenizer_core
    import slt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    slt_byte_if.sink     in_ch,
    slt_token_if.source  out_ch
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    mode_t                  mode_reg, mode_next;
    logic [VALUE_WIDTH-1:0] accum_reg, accum_next;
    result_t                ent_reg [2];
    result_t                ent_next [2];
    logic [1:0]             cnt_reg, cnt_next;

    logic       is_sep, is_ctrl, is_let, is_dig, is_word;
    logic       has_pre, has_st;
    result_t    pre_res, st_res, r0, r1;
    logic [1:0] n_res, base, space;
    logic       pop, proc_fire;
    logic [3:0] dval;
    logic [VALUE_WIDTH-1:0] accum_step;

    assign is_sep  = (in_byte_reg == CH_SPACE) || (in_byte_reg == CH_TAB);
    assign is_ctrl = (in_byte_reg < CTRL_LIMIT) && (in_byte_reg != CH_TAB);
    assign is_let  = is_letter(in_byte_reg);
    assign is_dig  = is_digit(in_byte_reg);
    assign is_word = is_let || is_dig || (in_byte_reg == CH_UNDERSCORE);
    assign dval    = 4'(in_byte_reg - CH_ZERO);
    assign accum_step = (accum_reg << 3) + (accum_reg << 1) + VALUE_WIDTH'(dval);

    // Next scan mode and accumulator.
    always_comb
    begin
        mode_next  = mode_reg;
        accum_next = accum_reg;
        case (mode_reg)
            MODE_LIT:
            begin
                mode_next = MODE_CLOSE;
            end
            MODE_CLOSE:
            begin
                mode_next = MODE_IDLE;
            end
            MODE_NUMBER:
            begin
                if (is_dig)
                begin
                    accum_next = accum_step;
                end
                else
                begin
                    accum_next = '0;
                end
            end
            default:
            begin
            end
        endcase
        if ((mode_reg == MODE_IDLE) || (mode_reg == MODE_IDENT && !is_word) ||
            (mode_reg == MODE_NUMBER && !is_dig))
        begin
            if (is_sep)
            begin
                mode_next = MODE_IDLE;
            end
            else if (is_ctrl)
            begin
                mode_next  = MODE_IDLE;
                accum_next = '0;
            end
            else if (is_let)
            begin
                mode_next = MODE_IDENT;
            end
            else if (is_dig)
            begin
                mode_next  = MODE_NUMBER;
                accum_next = VALUE_WIDTH'(dval);
            end
            else if (in_byte_reg == CH_QUOTE)
            begin
                mode_next = MODE_LIT;
            end
            else
            begin
                mode_next = MODE_IDLE;
            end
        end
    end

    // Events caused by the registered byte.
    always_comb
    begin
        has_pre = 1'b0;
        has_st  = 1'b0;
        pre_res = '{event_res: EV_ID_END, char_out: '0, token_value: '0, last: 1'b0};
        st_res  = '{event_res: EV_SYMBOL, char_out: in_byte_reg, token_value: '0,
                    last: 1'b1};
        case (mode_reg)
            MODE_IDENT:
            begin
                has_pre = 1'b1;
                if (is_word)
                begin
                    pre_res.event_res = EV_ID_CONT;
                    pre_res.char_out  = in_byte_reg;
                end
            end
            MODE_NUMBER:
            begin
                has_pre               = !is_dig;
                pre_res.event_res     = EV_NUMBER;
                pre_res.token_value   = 32'(accum_reg);
            end
            MODE_LIT:
            begin
                has_pre             = 1'b1;
                pre_res.event_res   = EV_CHAR;
                pre_res.token_value = {24'd0, in_byte_reg};
            end
            default:
            begin
            end
        endcase
        if ((mode_reg == MODE_IDLE) || (mode_reg == MODE_IDENT && !is_word) ||
            (mode_reg == MODE_NUMBER && !is_dig))
        begin
            if (is_ctrl)
            begin
                has_st           = 1'b1;
                st_res.event_res = EV_LINE_END;
                st_res.char_out  = '0;
            end
            else if (is_let)
            begin
                has_st           = 1'b1;
                st_res.event_res = EV_ID_START;
            end
            else if (!is_sep && !is_dig && (in_byte_reg != CH_QUOTE))
            begin
                has_st = 1'b1;
            end
        end
        n_res = {1'b0, has_pre} + {1'b0, has_st};
        r0    = has_pre ? pre_res : st_res;
        r1    = st_res;
        r0.last = (n_res == 2'd1);
    end

    assign pop       = out_ch.valid && out_ch.ready;
    assign base      = cnt_reg - {1'b0, pop};
    assign space     = 2'd2 - base;
    assign proc_fire = in_valid_reg && (n_res <= space);
    assign in_ch.ready = !in_valid_reg || proc_fire;

    // Result buffer update.
    always_comb
    begin
        ent_next[0] = ent_reg[0];
        ent_next[1] = ent_reg[1];
        if (pop)
        begin
            ent_next[0] = ent_reg[1];
        end
        if (proc_fire && n_res != 2'd0)
        begin
            if (base == 2'd0)
            begin
                ent_next[0] = r0;
                if (n_res == 2'd2)
                begin
                    ent_next[1] = r1;
                end
            end
            else
            begin
                ent_next[1] = r0;
            end
        end
        cnt_next = base + (proc_fire ? n_res : 2'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= MODE_IDLE;
            accum_reg    <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc_fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (proc_fire)
            begin
                mode_reg  <= mode_next;
                accum_reg <= accum_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_byte_reg <= in_ch.in_byte;
        end
        ent_reg[0] <= ent_next[0];
        ent_reg[1] <= ent_next[1];
    end

    assign out_ch.valid       = (cnt_reg != 2'd0);
    assign out_ch.event_res   = ent_reg[0].event_res;
    assign out_ch.char_out    = ent_reg[0].char_out;
    assign out_ch.token_value = ent_reg[0].token_value;
    assign out_ch.last        = ent_reg[0].last;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("result buffer count out of range");

    a_pair_room: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && n_res == 2'd2) |-> (base == 2'd0))
        else $error("two events scanned without room for both");

    a_lit_close: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && mode_reg == MODE_LIT) |=> (mode_reg == MODE_CLOSE))
        else $error("literal byte not followed by close wait");

    a_fire_count: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && !pop) |=> (cnt_reg == $past(cnt_reg) + $past(n_res)))
        else $error("result buffer count lost events");

endmodule

[sim/source_line_tokenizer_event_checker.sv]
`timescale 1ns / 100ps
// Event checker for the source line tokenizer: watches both channels, predicts the token
// events of every accepted byte and compares them beat by beat. Depends on slt_pkg,
// slt_byte_if and slt_token_if.
module source_line_tokenizer_event_checker
    import slt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    slt_byte_if   byte_bus,
    slt_token_if  token_bus,
    output int    mismatches,
    output int    pending,
    output int    events_checked
);

    localparam int DECIMAL_BASE = 10;

    mode_t                  scan_state = MODE_IDLE;
    logic [VALUE_WIDTH-1:0] digit_acc = '0;
    result_t                expected_events[$];
    int                     mismatch_count = 0;
    int                     event_count = 0;

    initial
    begin
        mismatches = 0;
        pending = 0;
        events_checked = 0;
    end

    function automatic logic letter_byte(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic decimal_byte(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void push_event(input event_t ev, input logic [7:0] ch,
                                       input logic [31:0] value);
        result_t r;
        r.event_res = ev;
        r.char_out = ch;
        r.token_value = value;
        r.last = 1'b0;
        expected_events.push_back(r);
    endfunction

    function automatic void open_token(input logic [7:0] c);
        if (c == CH_SPACE || c == CH_TAB)
        begin
            scan_state = MODE_IDLE;
        end
        else if (c < CTRL_LIMIT)
        begin
            scan_state = MODE_IDLE;
            digit_acc = '0;
            push_event(EV_LINE_END, 8'h00, 32'h0);
        end
        else if (letter_byte(c))
        begin
            scan_state = MODE_IDENT;
            push_event(EV_ID_START, c, 32'h0);
        end
        else if (decimal_byte(c))
        begin
            scan_state = MODE_NUMBER;
            digit_acc = VALUE_WIDTH'(c - CH_ZERO);
        end
        else if (c == CH_QUOTE)
        begin
            scan_state = MODE_LIT;
        end
        else
        begin
            scan_state = MODE_IDLE;
            push_event(EV_SYMBOL, c, 32'h0);
        end
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        int      queued_before;
        result_t tail;
        queued_before = expected_events.size();
        case (scan_state)
            MODE_IDENT:
            begin
                if (letter_byte(c) || decimal_byte(c) || c == CH_UNDERSCORE)
                begin
                    push_event(EV_ID_CONT, c, 32'h0);
                end
                else
                begin
                    push_event(EV_ID_END, 8'h00, 32'h0);
                    open_token(c);
                end
            end
            MODE_NUMBER:
            begin
                if (decimal_byte(c))
                begin
                    digit_acc = digit_acc * DECIMAL_BASE + VALUE_WIDTH'(c - CH_ZERO);
                end
                else
                begin
                    push_event(EV_NUMBER, 8'h00, 32'(digit_acc));
                    digit_acc = '0;
                    open_token(c);
                end
            end
            MODE_LIT:
            begin
                push_event(EV_CHAR, 8'h00, 32'(c));
                scan_state = MODE_CLOSE;
            end
            MODE_CLOSE:
            begin
                scan_state = MODE_IDLE;
            end
            default:
            begin
                scan_state = MODE_IDLE;
                open_token(c);
            end
        endcase
        if (expected_events.size() > queued_before)
        begin
            tail = expected_events.pop_back();
            tail.last = 1'b1;
            expected_events.push_back(tail);
        end
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void check_event();
        result_t want;
        event_count++;
        if (expected_events.size() == 0)
        begin
            $error("token beat with nothing expected: event_res %0d char_out 0x%0h",
                   token_bus.event_res, token_bus.char_out);
            mismatch_count++;
        end
        else
        begin
            want = expected_events.pop_front();
            check_field("event_res", 32'(want.event_res), 32'(token_bus.event_res));
            check_field("char_out", 32'(want.char_out), 32'(token_bus.char_out));
            check_field("token_value", want.token_value, token_bus.token_value);
            check_field("last", 32'(want.last), 32'(token_bus.last));
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_state = MODE_IDLE;
            digit_acc = '0;
            expected_events.delete();
        end
        else
        begin
            if (byte_bus.valid && byte_bus.ready)
            begin
                scan_byte(byte_bus.in_byte);
            end
            if (token_bus.valid && token_bus.ready)
            begin
                check_event();
            end
        end
        mismatches <= mismatch_count;
        pending <= expected_events.size();
        events_checked <= event_count;
    end

endmodule

[sim/source_line_tokenizer_core_test.sv]
`timescale 1ns / 100ps
// Testbench top for source_line_tokenizer_core: drives source bytes and output stalls,
// and gives the verdict from the event checker. Depends on slt_pkg, both channel
// interfaces, the tokenizer RTL and source_line_tokenizer_event_checker.
module source_line_tokenizer_core_test;
    import slt_pkg::*;

    localparam int TARGET_ITEMS = 1900;
    localparam int HOLD_START_ITEM = 900;
    localparam int HOLD_CYCLES = 300;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] OPENING_BYTES [0:22] = '{
        "a", "Z", "_", "9", CH_TAB, "0", "7", 8'hFF, "_", CH_QUOTE, 8'h00, CH_NEWLINE,
        8'h0D, 8'h00, CH_QUOTE, 8'hFF, "x", "1", "2", "a", 8'h1F, CH_SPACE, 8'h7F
    };

    logic clk = 1'b0;
    logic rst_n;
    bit   hold_off_req = 1'b0;
    int   burst_left = 1;
    int   bytes_sent = 0;
    int   mismatches;
    int   pending;
    int   events_checked;

    slt_byte_if  byte_bus ();
    slt_token_if token_bus ();

    source_line_tokenizer_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (byte_bus),
        .out_ch (token_bus)
    );

    source_line_tokenizer_event_checker checker_u (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_bus       (byte_bus),
        .token_bus      (token_bus),
        .mismatches     (mismatches),
        .pending        (pending),
        .events_checked (events_checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        byte_bus.valid <= 1'b1;
        byte_bus.in_byte <= b;
        do @(posedge clk); while (!byte_bus.ready);
        bytes_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        if (burst_left == 0 && !hold_off_req)
        begin
            byte_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    function automatic logic [7:0] random_letter();
        logic [7:0] c;
        c = 8'($urandom_range(0, 25));
        return $urandom_range(0, 1) ? c + "a" : c + "A";
    endfunction

    task automatic send_token();
        logic [7:0] c;
        int         count;
        int         kind;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            send_byte(random_letter());
            count = $urandom_range(0, 7);
            repeat (count)
            begin
                case ($urandom_range(0, 3))
                    0: c = 8'($urandom_range(CH_ZERO, CH_NINE));
                    1: c = CH_UNDERSCORE;
                    default: c = random_letter();
                endcase
                send_byte(c);
            end
        end
        else if (kind < 50)
        begin
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
            repeat (count) send_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
        end
        else if (kind < 60)
        begin
            send_byte(CH_QUOTE);
            send_byte(8'($urandom_range(0, 255)));
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (kind < 72)
        begin
            do
                c = 8'($urandom_range(8'h21, 8'hFF));
            while ((c >= CH_ZERO && c <= CH_NINE) || (c >= "A" && c <= "Z")
                   || (c >= "a" && c <= "z") || c == CH_QUOTE);
            send_byte(c);
        end
        else if (kind < 86)
        begin
            count = $urandom_range(1, 3);
            repeat (count) send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
        end
        else if (kind < 94)
        begin
            do
                c = 8'($urandom_range(0, CTRL_LIMIT - 1));
            while (c == CH_TAB);
            send_byte(c);
        end
        else
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin : output_stalls
        int ready_pct;
        int window_left;
        ready_pct = 100;
        window_left = 0;
        token_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                token_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                if (window_left == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: ready_pct = 100;
                        1: ready_pct = 80;
                        2: ready_pct = 45;
                        default: ready_pct = 15;
                    endcase
                    window_left = $urandom_range(20, 120);
                end
                window_left--;
                token_bus.ready <= ($urandom_range(1, 100) <= ready_pct);
            end
        end
    end

    initial
    begin : stimulus
        bit hold_done;
        hold_done = 1'b0;
        rst_n <= 1'b0;
        byte_bus.valid <= 1'b0;
        byte_bus.in_byte <= 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (OPENING_BYTES[i])
        begin
            send_byte(OPENING_BYTES[i]);
        end
        while (bytes_sent < TARGET_ITEMS)
        begin
            if (!hold_done && bytes_sent >= HOLD_START_ITEM)
            begin
                hold_off_req = 1'b1;
                hold_done = 1'b1;
            end
            send_token();
        end
        send_byte(CH_NEWLINE);
        byte_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        $display("Covered %0d source bytes and %0d token events, with random bursts, stalls",
                 bytes_sent, events_checked);
        $display("and one %0d-cycle output hold-off that backed up the byte input.", HOLD_CYCLES);
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
